// ===== hdl/allele_count_site_filter_assert.svh =====
// assertion macros shared by the parser and top-level site filter modules
`ifndef ALLELE_COUNT_SITE_FILTER_ASSERT_SVH
`define ALLELE_COUNT_SITE_FILTER_ASSERT_SVH

// same-cycle implication
`define ACSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ACSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/acsf_pkg.sv =====
// types, constants and codes of the allele count site filter
package acsf_pkg;

  localparam int COUNT_WIDTH    = 16;
  localparam int SKIPPED_FIELDS = 3;
  localparam int LANES          = 4;
  localparam int CFG_WIDTH      = 16;

  localparam int ACC_W   = COUNT_WIDTH + 4;
  localparam int FIELD_W = $clog2(SKIPPED_FIELDS + 2);
  localparam int CPOS_W  = $clog2(LANES + 1);
  localparam int LANE_W  = $clog2(LANES);
  localparam int CMP_W   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  localparam logic [FIELD_W-1:0] POP1_FIELD = FIELD_W'(SKIPPED_FIELDS);
  localparam logic [FIELD_W-1:0] POP2_FIELD = FIELD_W'(SKIPPED_FIELDS + 1);
  localparam logic [CPOS_W-1:0]  CPOS_FULL  = CPOS_W'(LANES);

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic REG_MIN_COVERAGE = 1'b0;
  localparam logic REG_DIPLOID_MODE = 1'b1;

  localparam logic [CFG_WIDTH-1:0] MIN_COVERAGE_RESET = CFG_WIDTH'(1);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef count_t [LANES-1:0] lanes_t;

  typedef struct packed {
    logic   done;
    lanes_t pop1;
    lanes_t pop2;
  } line_t;

endpackage

// ===== hdl/acsf_parser.sv =====
// line parser: field tracking, count parsing and count storage
`include "allele_count_site_filter_assert.svh"

module acsf_parser
  import acsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] text_byte,
  output line_t      line
);

  logic [FIELD_W-1:0] field_position, field_position_next;
  logic [CPOS_W-1:0]  count_position, count_position_next;
  count_t             digit_accumulator, digit_accumulator_next;
  lanes_t             first_pop_counts, first_pop_counts_next;
  lanes_t             second_pop_counts, second_pop_counts_next;
  logic               line_nonempty, line_nonempty_next;
  logic               done;
  logic               in_pop;
  logic [ACC_W-1:0]   acc_wide;
  logic [7:0]         digit_off;

  assign in_pop    = (field_position == POP1_FIELD) || (field_position == POP2_FIELD);
  assign digit_off = text_byte - CHAR_ZERO;
  assign acc_wide  = (ACC_W'(digit_accumulator) << 3) + (ACC_W'(digit_accumulator) << 1)
                   + ACC_W'(digit_off[3:0]);

  always_comb begin
    field_position_next    = field_position;
    count_position_next    = count_position;
    digit_accumulator_next = digit_accumulator;
    first_pop_counts_next  = first_pop_counts;
    second_pop_counts_next = second_pop_counts;
    line_nonempty_next     = line_nonempty;
    done                   = 1'b0;
    if (in_valid) begin
      if (text_byte == CHAR_NL) begin
        done                   = line_nonempty;
        field_position_next    = '0;
        count_position_next    = '0;
        digit_accumulator_next = '0;
        first_pop_counts_next  = '0;
        second_pop_counts_next = '0;
        line_nonempty_next     = 1'b0;
      end else begin
        line_nonempty_next = 1'b1;
        if (text_byte == CHAR_TAB) begin
          if (field_position < POP2_FIELD) begin
            field_position_next    = field_position + FIELD_W'(1);
            count_position_next    = '0;
            digit_accumulator_next = '0;
          end
        end else if (in_pop && (count_position < CPOS_FULL)) begin
          if (text_byte == CHAR_COLON) begin
            if (field_position == POP1_FIELD) begin
              first_pop_counts_next[count_position[LANE_W-1:0]] = digit_accumulator;
            end else begin
              second_pop_counts_next[count_position[LANE_W-1:0]] = digit_accumulator;
            end
            count_position_next    = count_position + CPOS_W'(1);
            digit_accumulator_next = '0;
          end else if ((text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE)) begin
            // saturate at the top of the count range
            if (acc_wide[ACC_W-1:COUNT_WIDTH] != '0) begin
              digit_accumulator_next = '1;
            end else begin
              digit_accumulator_next = acc_wide[COUNT_WIDTH-1:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_position    <= '0;
      count_position    <= '0;
      digit_accumulator <= '0;
      first_pop_counts  <= '0;
      second_pop_counts <= '0;
      line_nonempty     <= 1'b0;
    end else begin
      field_position    <= field_position_next;
      count_position    <= count_position_next;
      digit_accumulator <= digit_accumulator_next;
      first_pop_counts  <= first_pop_counts_next;
      second_pop_counts <= second_pop_counts_next;
      line_nonempty     <= line_nonempty_next;
    end
  end

  assign line.done = done;
  assign line.pop1 = first_pop_counts;
  assign line.pop2 = second_pop_counts;

  `ACSF_ASSERT_NOW(a_cpos_range, 1'b1, count_position <= CPOS_FULL, "count position out of range")
  `ACSF_ASSERT_NOW(a_field_range, 1'b1, field_position <= POP2_FIELD, "field position out of range")
  `ACSF_ASSERT_NEXT(a_newline_clears, in_valid && (text_byte == CHAR_NL),
    (field_position == '0) && (count_position == '0) && !line_nonempty, "line state not cleared")

endmodule

// ===== hdl/acsf_decide.sv =====
// four-lane site decision from the two populations' counts
module acsf_decide
  import acsf_pkg::*;
(
  input  lanes_t               pop1,
  input  lanes_t               pop2,
  input  logic [CFG_WIDTH-1:0] min_coverage,
  input  logic                 diploid_mode,
  output logic                 site_selected
);

  logic [CPOS_W-1:0] evidence;
  logic [CPOS_W-1:0] alleles1;
  logic [CPOS_W-1:0] alleles2;
  logic              differs;
  logic [CMP_W-1:0]  p;
  logic [CMP_W-1:0]  q;
  logic [CMP_W-1:0]  min_cov;
  logic              p_zero;
  logic              q_zero;

  assign min_cov = CMP_W'(min_coverage);

  always_comb begin
    evidence = '0;
    alleles1 = '0;
    alleles2 = '0;
    differs  = 1'b0;
    p        = '0;
    q        = '0;
    p_zero   = 1'b0;
    q_zero   = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      p      = CMP_W'(pop1[i]);
      q      = CMP_W'(pop2[i]);
      p_zero = (p == '0);
      q_zero = (q == '0);
      if (p_zero && !q_zero) begin
        if (q >= min_cov) differs = 1'b1;
      end else if (q_zero && !p_zero) begin
        if (p >= min_cov) differs = 1'b1;
      end
      if (!p_zero) alleles1 = alleles1 + CPOS_W'(1);
      if (!q_zero) alleles2 = alleles2 + CPOS_W'(1);
      if ((p > q) && ((p >> 1) > q)) begin
        if (p >= min_cov) evidence = evidence + CPOS_W'(1);
      end else if ((q > p) && p_zero) begin
        if (q >= min_cov) evidence = evidence + CPOS_W'(1);
      end
    end
  end

  assign site_selected = (evidence >= CPOS_W'(2)) && differs
                       && !(diploid_mode && ((alleles1 > CPOS_W'(2)) || (alleles2 > CPOS_W'(2))));

endmodule

// ===== hdl/allele_count_site_filter.sv =====
// top level of the allele count site filter
//
// s_tvalid/s_tready/s_tdata carry one ASCII byte of a tab-separated
// allele-count line per request. Every byte is parsed in the cycle it is
// accepted, so a new byte may be taken on every clock edge.
// m_tvalid/m_tready/m_tdata carry one flag per non-blank line; a blank
// line gives no request. When a line's newline is accepted, its counts are
// captured in the capture register; the decision on them is then
// registered in the output register once that register is free.
// cfg_we/cfg_index/cfg_data write min_coverage (index 0) and
// diploid_mode (index 1); write them only while the block is idle.
// Reset clears all line state, sets min_coverage to 1 and diploid_mode
// to 0. When the receiver stalls, the pending flag holds in the output
// register and one more finished line waits in the capture register;
// after that s_tready drops until the output is taken.
`include "allele_count_site_filter_assert.svh"

module allele_count_site_filter
  import acsf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] text_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [0] site_selected, [7:1] zero
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  logic [CFG_WIDTH-1:0] min_coverage;
  logic                 diploid_mode;
  line_t                line;
  logic                 pend;
  lanes_t               snap_pop1;
  lanes_t               snap_pop2;
  logic                 out_valid;
  logic                 out_sel;
  logic                 out_free;
  logic                 in_acc;
  logic                 sel;

  assign out_free = !out_valid || m_tready;
  assign s_tready = !pend || out_free;
  assign in_acc   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_coverage <= MIN_COVERAGE_RESET;
      diploid_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_COVERAGE: min_coverage <= cfg_data;
        REG_DIPLOID_MODE: diploid_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  acsf_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_acc),
    .text_byte (s_tdata),
    .line      (line)
  );

  // capture of a finished line
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (line.done) begin
      pend <= 1'b1;
    end else if (out_free) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line.done) begin
      snap_pop1 <= line.pop1;
      snap_pop2 <= line.pop2;
    end
  end

  acsf_decide u_decide (
    .pop1          (snap_pop1),
    .pop2          (snap_pop2),
    .min_coverage  (min_coverage),
    .diploid_mode  (diploid_mode),
    .site_selected (sel)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend) begin
      out_sel <= sel;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_sel};

  `ACSF_ASSERT_NOW(a_stall_blocks_input, pend && !out_free, !s_tready, "input taken while full")
  `ACSF_ASSERT_NEXT(a_line_captured, line.done, pend, "finished line not captured")
  `ACSF_ASSERT_NEXT(a_capture_moves_out, pend && out_free, m_tvalid, "captured line not moved out")

endmodule
